>>> design/hpi_pkg.sv
package hpi_pkg;

	localparam int TRIG_ITERATIONS_DEF        = 16;
	localparam int POSITION_FRACTION_BITS_DEF = 16;

	localparam int CORDIC_W    = 34;  // Q2.30 plus guard bits
	localparam int TRIG_W      = 18;  // cos and sin in Q.16, +/-65536 included
	localparam int ATAN_IDX_W  = 5;
	localparam int MUL_A_W     = 36;
	localparam int MUL_B_W     = 18;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int WV_W        = 35;  // world velocity, Q.24
	localparam int POS_W       = 32;
	localparam int HEAD_W      = 16;
	localparam int DTJ_W       = 17;
	localparam int IN_DATA_W   = 136;
	localparam int OUT_DATA_W  = 184;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [15:0] STEP_PERIOD_RESET = 16'd1311;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRIG,
		ST_MUL,
		ST_EMIT
	} state_t;

	// products run through the shared multiplier, in issue order
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_VXC,
		OP_VYS,
		OP_VXS,
		OP_VYC,
		OP_WXDT,
		OP_WYDT,
		OP_CDT,
		OP_SDT,
		OP_WZDT
	} mul_op_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	// atan(2^-i) with a full turn at 2^32
	function automatic logic signed [CORDIC_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] i);
		case (i)
			5'd0:    atan_lookup = 34'sd536870912;
			5'd1:    atan_lookup = 34'sd316933406;
			5'd2:    atan_lookup = 34'sd167458907;
			5'd3:    atan_lookup = 34'sd85004756;
			5'd4:    atan_lookup = 34'sd42667331;
			5'd5:    atan_lookup = 34'sd21354465;
			5'd6:    atan_lookup = 34'sd10679838;
			5'd7:    atan_lookup = 34'sd5340245;
			5'd8:    atan_lookup = 34'sd2670163;
			5'd9:    atan_lookup = 34'sd1335087;
			5'd10:   atan_lookup = 34'sd667544;
			5'd11:   atan_lookup = 34'sd333772;
			5'd12:   atan_lookup = 34'sd166886;
			5'd13:   atan_lookup = 34'sd83443;
			5'd14:   atan_lookup = 34'sd41722;
			5'd15:   atan_lookup = 34'sd20861;
			5'd16:   atan_lookup = 34'sd10430;
			5'd17:   atan_lookup = 34'sd5215;
			5'd18:   atan_lookup = 34'sd2608;
			5'd19:   atan_lookup = 34'sd1304;
			5'd20:   atan_lookup = 34'sd652;
			5'd21:   atan_lookup = 34'sd326;
			5'd22:   atan_lookup = 34'sd163;
			5'd23:   atan_lookup = 34'sd81;
			default: atan_lookup = '0;
		endcase
	endfunction

	function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
		if (v > 34'sd65536) begin
			clamp_unit = 18'sd65536;
		end else if (v < -34'sd65536) begin
			clamp_unit = -18'sd65536;
		end else begin
			clamp_unit = v[TRIG_W-1:0];
		end
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		if ((&v[SUM_W-1:POS_W-1]) || !(|v[SUM_W-1:POS_W-1])) begin
			sat32 = v[POS_W-1:0];
		end else if (v[SUM_W-1]) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = 32'sh7FFF_FFFF;
		end
	endfunction

endpackage

>>> design/holonomic_pose_integrator.sv
// a step item runs the iterative sine-cosine and then nine products through one multiplier
// before its result is emitted; a load item goes straight to the emit state
// an item is taken only in idle, so a new item waits until the last one has been emitted
// reset: pose clears to zero, step_period returns to 1311, no result is pending
module holonomic_pose_integrator #(
	parameter int TRIG_ITERATIONS        = hpi_pkg::TRIG_ITERATIONS_DEF,
	parameter int POSITION_FRACTION_BITS = hpi_pkg::POSITION_FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [15:0]                        cfg_wr_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// load_x, load_y, load_heading, vel_x, vel_y, yaw_rate
	input  logic [hpi_pkg::IN_DATA_W-1:0]      s_tdata,
	// func
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pose_x_out, pose_y_out, heading_out, yaw_to_x_gain, yaw_to_y_gain, dt_cos, dt_sin, zero pad
	output logic [hpi_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import hpi_pkg::*;

	localparam int POS_SHIFT = 40 - POSITION_FRACTION_BITS;
	localparam logic signed [PROD_W:0] POS_BIAS = {{PROD_W{1'b0}}, 1'b1} << (POS_SHIFT - 1);

	state_t  state_q, state_nx;
	mul_op_t iss_q, cons_q, iss_nx;

	logic [15:0]              step_period_q;
	logic signed [POS_W-1:0]  pose_x_q, pose_y_q, gain_x_q, gain_y_q;
	logic signed [HEAD_W-1:0] pose_h_q;
	logic signed [DTJ_W-1:0]  dt_cos_q, dt_sin_q;
	logic signed [15:0]       vel_x_q, vel_y_q;
	logic signed [23:0]       yaw_rate_q;
	logic signed [WV_W-1:0]   wx_q, wy_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	logic                     accept, cordic_start, cordic_done, emit_fire, out_free;
	trig_t                    trig;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b, dt_op;
	logic signed [PROD_W-1:0]  p_s1;
	logic signed [PROD_W:0]    rnd_pos, d_pos, rnd16;
	logic signed [SUM_W-1:0]   d_ext, neg_d, pose_sum;
	logic signed [POS_W-1:0]   pose_sel;

	hpi_cordic #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.heading(pose_h_q),
		.done   (cordic_done),
		.trig   (trig)
	);

	hpi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_s1(p_s1)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = s_tuser ? ST_TRIG : ST_EMIT;
			end
			ST_TRIG: begin
				if (cordic_done) state_nx = ST_MUL;
			end
			ST_MUL: begin
				if (cons_q == OP_WZDT) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		accept       = s_tvalid && (state_q == ST_IDLE);
		cordic_start = accept && s_tuser;
		emit_fire    = (state_q == ST_EMIT) && out_free;
	end

	always_comb begin
		case (iss_q)
			OP_VXC:  iss_nx = OP_VYS;
			OP_VYS:  iss_nx = OP_VXS;
			OP_VXS:  iss_nx = OP_VYC;
			OP_VYC:  iss_nx = OP_WXDT;
			OP_WXDT: iss_nx = OP_WYDT;
			OP_WYDT: iss_nx = OP_CDT;
			OP_CDT:  iss_nx = OP_SDT;
			OP_SDT:  iss_nx = OP_WZDT;
			default: iss_nx = OP_IDLE;
		endcase
	end

	// operand select for the shared multiplier
	assign dt_op = MUL_B_W'(signed'({1'b0, step_period_q}));
	always_comb begin
		case (iss_q)
			OP_VXC:  begin mul_a = MUL_A_W'(vel_x_q);     mul_b = trig.cos_v; end
			OP_VYS:  begin mul_a = MUL_A_W'(vel_y_q);     mul_b = trig.sin_v; end
			OP_VXS:  begin mul_a = MUL_A_W'(vel_x_q);     mul_b = trig.sin_v; end
			OP_VYC:  begin mul_a = MUL_A_W'(vel_y_q);     mul_b = trig.cos_v; end
			OP_WXDT: begin mul_a = MUL_A_W'(wx_q);        mul_b = dt_op;      end
			OP_WYDT: begin mul_a = MUL_A_W'(wy_q);        mul_b = dt_op;      end
			OP_CDT:  begin mul_a = MUL_A_W'(trig.cos_v);  mul_b = dt_op;      end
			OP_SDT:  begin mul_a = MUL_A_W'(trig.sin_v);  mul_b = dt_op;      end
			OP_WZDT: begin mul_a = MUL_A_W'(yaw_rate_q);  mul_b = dt_op;      end
			default: begin mul_a = '0;                    mul_b = '0;         end
		endcase
	end

	// round half up of the product, then add into the position with saturation
	always_comb begin
		rnd_pos  = (PROD_W+1)'(p_s1) + POS_BIAS;
		d_pos    = rnd_pos >>> POS_SHIFT;
		d_ext    = SUM_W'(d_pos);
		neg_d    = -d_ext;
		pose_sel = (cons_q == OP_WYDT) ? pose_y_q : pose_x_q;
		pose_sum = d_ext + SUM_W'(pose_sel);
		rnd16    = (PROD_W+1)'(p_s1) + 55'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			iss_q         <= OP_IDLE;
			cons_q        <= OP_IDLE;
			step_period_q <= STEP_PERIOD_RESET;
			pose_x_q      <= '0;
			pose_y_q      <= '0;
			pose_h_q      <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) step_period_q <= cfg_wr_data;
			if (state_q == ST_TRIG && cordic_done) begin
				iss_q  <= OP_VXC;
				cons_q <= OP_IDLE;
			end else if (state_q == ST_MUL) begin
				iss_q  <= iss_nx;
				cons_q <= iss_q;
			end
			if (accept && !s_tuser) begin
				pose_x_q <= s_tdata[31:0];
				pose_y_q <= s_tdata[63:32];
				pose_h_q <= s_tdata[79:64];
			end else if (state_q == ST_MUL) begin
				case (cons_q)
					OP_WXDT: pose_x_q <= sat32(pose_sum);
					OP_WYDT: pose_y_q <= sat32(pose_sum);
					OP_WZDT: pose_h_q <= pose_h_q + rnd16[31:16];
					default: ;
				endcase
			end
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vel_x_q    <= s_tdata[95:80];
			vel_y_q    <= s_tdata[111:96];
			yaw_rate_q <= s_tdata[135:112];
			if (!s_tuser) begin
				gain_x_q <= '0;
				gain_y_q <= '0;
				dt_cos_q <= '0;
				dt_sin_q <= '0;
			end
		end
		if (state_q == ST_MUL) begin
			case (cons_q)
				OP_VXC:  wx_q     <= WV_W'(p_s1);
				OP_VYS:  wx_q     <= wx_q - WV_W'(p_s1);
				OP_VXS:  wy_q     <= WV_W'(p_s1);
				OP_VYC:  wy_q     <= wy_q + WV_W'(p_s1);
				OP_WXDT: gain_y_q <= sat32(d_ext);
				OP_WYDT: gain_x_q <= sat32(neg_d);
				OP_CDT:  dt_cos_q <= rnd16[32:16];
				OP_SDT:  dt_sin_q <= rnd16[32:16];
				default: ;
			endcase
		end
		if (emit_fire) begin
			m_tdata_q <= {6'b0, dt_sin_q, dt_cos_q, gain_y_q, gain_x_q,
				pose_h_q, pose_y_q, pose_x_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> design/hpi_mul.sv
module hpi_mul (
	input  logic                              clk,
	input  logic signed [hpi_pkg::MUL_A_W-1:0] a,
	input  logic signed [hpi_pkg::MUL_B_W-1:0] b,
	output logic signed [hpi_pkg::PROD_W-1:0]  p_s1
);
	import hpi_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

>>> design/hpi_cordic.sv
module hpi_cordic #(
	parameter int TRIG_ITERATIONS = hpi_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [hpi_pkg::HEAD_W-1:0] heading,
	output logic                             done,
	output hpi_pkg::trig_t                   trig
);
	import hpi_pkg::*;

	localparam int ITW = $clog2(TRIG_ITERATIONS + 1);

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [CORDIC_W-1:0] x_sh, y_sh, x_rnd, y_rnd, atan_v;
	logic signed [TRIG_W-1:0]   x_cl, y_cl;
	logic signed [HEAD_W:0]     h_ext, h_red;
	logic                       flip, flip_q;
	logic [ITW-1:0]             it_q;
	logic                       busy_q, done_q, last;
	trig_t                      trig_q;

	// fold into [-pi/2, pi/2]; the half turn negates both results
	always_comb begin
		h_ext = (HEAD_W+1)'(heading);
		flip  = 1'b0;
		h_red = h_ext;
		if (h_ext > 17'sd16384) begin
			h_red = h_ext - 17'sd32768;
			flip  = 1'b1;
		end else if (h_ext < -17'sd16384) begin
			h_red = h_ext + 17'sd32768;
			flip  = 1'b1;
		end
	end

	assign last   = busy_q && (it_q == ITW'(TRIG_ITERATIONS));
	assign x_sh   = x_q >>> it_q;
	assign y_sh   = y_q >>> it_q;
	assign atan_v = atan_lookup(ATAN_IDX_W'(it_q));
	assign x_rnd  = (x_q + 34'sd8192) >>> 14;
	assign y_rnd  = (y_q + 34'sd8192) >>> 14;
	assign x_cl   = clamp_unit(x_rnd);
	assign y_cl   = clamp_unit(y_rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= last;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (last) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				it_q <= it_q + ITW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= CORDIC_W'(h_red) <<< 16;
			flip_q <= flip;
		end else if (busy_q && !last) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
		end
		if (last) begin
			trig_q.cos_v <= flip_q ? -x_cl : x_cl;
			trig_q.sin_v <= flip_q ? -y_cl : y_cl;
		end
	end

	assign done = done_q;
	assign trig = trig_q;

endmodule
